@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Wrappers for concurrent assertions; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked at every edge with reset inactive
`define CJST_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cjst assertion failed");
// checked at every edge, reset included
`define CJST_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("cjst assertion failed");
`else
`define CJST_ASSERT(lbl, clk, rst_n, prop)
`define CJST_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hdl/cjst_pkg.sv @@
// ---------------------------------------------------------------------------
// Job slot table package
// Beat types, opcodes, slot states and result codes.
// ---------------------------------------------------------------------------
package cjst_pkg;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	localparam logic [1:0] ST_FREE      = 2'd0;
	localparam logic [1:0] ST_COUNTING  = 2'd1;
	localparam logic [1:0] ST_FIRED     = 2'd2;
	localparam logic [1:0] ST_CANCELLED = 2'd3;

	localparam logic [2:0] RES_OK        = 3'd0;
	localparam logic [2:0] RES_INVALID   = 3'd1;
	localparam logic [2:0] RES_NOSPACE   = 3'd2;
	localparam logic [2:0] RES_CANCELLED = 3'd3;
	localparam logic [2:0] RES_BUSY      = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] seconds;
		logic [7:0]  action_code;
		logic [31:0] job_tag;
		logic [7:0]  slot_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  slot_out;
		logic        fired;
		logic [7:0]  action_out;
		logic [31:0] tag_out;
		logic        last;
	} rsp_t;

	// per-slot job payload
	typedef struct packed {
		logic [15:0] seconds;
		logic [7:0]  action;
		logic [31:0] tag;
	} job_t;

	// store write strobes
	typedef struct packed {
		logic wr_secs;	// countdown only
		logic wr_job;	// whole job
	} store_ctl_t;

endpackage

@@ hdl/cjst_store.sv @@
// ---------------------------------------------------------------------------
// Job slot payload store
// Countdown, action and tag memories; one write, one registered read.
// ---------------------------------------------------------------------------
module cjst_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                    clk,
	input  cjst_pkg::store_ctl_t    ctl,
	input  logic [AW-1:0]           wr_addr,
	input  cjst_pkg::job_t          wr_data,
	input  logic [AW-1:0]           rd_addr,
	output cjst_pkg::job_t          rd_data
);
	import cjst_pkg::*;

	logic [15:0] mem_secs [DEPTH];
	logic [7:0]  mem_act  [DEPTH];
	logic [31:0] mem_tag  [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_secs || ctl.wr_job) begin
			mem_secs[wr_addr] <= wr_data.seconds;
		end
		if (ctl.wr_job) begin
			mem_act[wr_addr] <= wr_data.action;
			mem_tag[wr_addr] <= wr_data.tag;
		end
	end

	always_ff @(posedge clk) begin
		rd_data.seconds <= mem_secs[rd_addr];
		rd_data.action  <= mem_act[rd_addr];
		rd_data.tag     <= mem_tag[rd_addr];
	end

endmodule

@@ hdl/cjst_alu.sv @@
// ---------------------------------------------------------------------------
// Countdown unit
// Shared compare and decrement applied to one slot per cycle.
// ---------------------------------------------------------------------------
module cjst_alu (
	input  logic [15:0] secs,
	output logic        fire,
	output logic [15:0] dec
);
	// a count of one or less expires on this tick
	assign fire = (secs <= 16'd1);
	assign dec  = secs - 16'd1;

endmodule

@@ hdl/countdown_job_slot_table.sv @@
// ---------------------------------------------------------------------------
// Countdown job slot table
// Table of job slots with add, cancel and one-second tick commands.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: a beat on cmd is taken at a rising edge with start high
//   and busy low. Result channel: each result beat sits on rsp for exactly
//   one cycle with strobe high; the receiver cannot stall it.
//   Cancel, a rejected add and the unused opcode answer in the cycle after
//   the command; busy does not rise.
//   A valid add walks the slot status from slot 0 until it finds a free slot
//   or else answers no space; the result comes in the cycle busy falls.
//   A tick walks every slot through the payload store, one slot per cycle
//   with a registered read. Each firing slot yields one beat, in slot order;
//   the last beat carries last = 1.
//   A tick without firings yields a single all-zero beat with last = 1.
//   Busy drops in the same cycle as the final beat, so a new command can be
//   issued then. The throughput is set by the single store read port and the
//   one shared countdown unit.
//   Reset frees all slots; the payload memories are not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module countdown_job_slot_table #(
	parameter int SLOT_COUNT = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cjst_pkg::cmd_t cmd,
	output logic           strobe,
	output cjst_pkg::rsp_t rsp
);
	import cjst_pkg::*;

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADD  = 2'd1;
	localparam logic [1:0] S_TICK = 2'd2;
	localparam logic [1:0] S_END  = 2'd3;

	// sequencer state
	logic [1:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;	// scan / read pointer
	logic          v_s1, v_d;	// store read in flight
	logic [IW-1:0] idx_s1;

	// slot status, reset to free
	logic [1:0] status_q [SLOT_COUNT];
	logic          st_we;
	logic [IW-1:0] st_widx;
	logic [1:0]    st_wval;

	// held command for add
	cmd_t cmd_q;

	// pending fired beat; we only know it is the last one at scan end
	logic          pend_v_q, pend_load, pend_clr;
	logic [IW-1:0] pend_slot_q;
	logic [7:0]    pend_act_q;
	logic [31:0]   pend_tag_q;

	// result register
	logic emit, strobe_q;
	rsp_t rsp_d, rsp_q;

	// store and countdown unit
	store_ctl_t    ctl;
	logic [IW-1:0] wr_addr;
	job_t          wr_data, rd_data;
	logic          fire;
	logic [15:0]   dec;

	logic [IW-1:0] id_idx, scan_idx;
	logic [1:0]    st_id, st_scan, st_s1;

	assign id_idx   = cmd.slot_id[IW-1:0];
	assign scan_idx = cnt_q[IW-1:0];
	assign st_scan  = status_q[scan_idx];
	assign st_s1    = status_q[idx_s1];

	cjst_store #(
		.DEPTH (SLOT_COUNT),
		.AW    (IW)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (scan_idx),
		.rd_data (rd_data)
	);

	cjst_alu u_alu (
		.secs (rd_data.seconds),
		.fire (fire),
		.dec  (dec)
	);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		v_d       = 1'b0;
		st_we     = 1'b0;
		st_widx   = idx_s1;
		st_wval   = ST_FREE;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		emit      = 1'b0;
		rsp_d     = '0;
		ctl       = '0;
		wr_addr   = idx_s1;
		wr_data   = rd_data;
		st_id     = ST_FREE;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.mode)
						MODE_ADD: begin
							if (cmd.seconds == 16'd0 || cmd.action_code == 8'd0) begin
								emit         = 1'b1;
								rsp_d.status = RES_INVALID;
								rsp_d.last   = 1'b1;
							end else begin
								state_d = S_ADD;
								cnt_d   = '0;
							end
						end
						MODE_CANCEL: begin
							emit       = 1'b1;
							rsp_d.last = 1'b1;
							// out-of-range ids never index the status array
							if (cmd.slot_id >= 8'(SLOT_COUNT)) begin
								rsp_d.status = RES_INVALID;
							end else begin
								st_id = status_q[id_idx];
								case (st_id)
									ST_FREE:      rsp_d.status = RES_INVALID;
									ST_CANCELLED: rsp_d.status = RES_CANCELLED;
									ST_FIRED:     rsp_d.status = RES_BUSY;
									default: begin
										rsp_d.status = RES_OK;
										st_we   = 1'b1;
										st_widx = id_idx;
										st_wval = ST_CANCELLED;
									end
								endcase
							end
						end
						MODE_TICK: begin
							state_d  = S_TICK;
							cnt_d    = '0;
							pend_clr = 1'b1;
						end
						default: begin
							emit         = 1'b1;
							rsp_d.status = RES_INVALID;
							rsp_d.last   = 1'b1;
						end
					endcase
				end
			end
			S_ADD: begin
				if (st_scan == ST_FREE) begin
					st_we           = 1'b1;
					st_widx         = scan_idx;
					st_wval         = ST_COUNTING;
					ctl.wr_job      = 1'b1;
					wr_addr         = scan_idx;
					wr_data.seconds = cmd_q.seconds;
					wr_data.action  = cmd_q.action_code;
					wr_data.tag     = cmd_q.job_tag;
					emit            = 1'b1;
					rsp_d.status    = RES_OK;
					rsp_d.slot_out  = 8'(scan_idx);
					rsp_d.last      = 1'b1;
					state_d         = S_IDLE;
				end else if (scan_idx == IW'(SLOT_COUNT - 1)) begin
					emit         = 1'b1;
					rsp_d.status = RES_NOSPACE;
					rsp_d.last   = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_TICK: begin
				// issue reads for every slot
				if (cnt_q != CW'(SLOT_COUNT)) begin
					v_d   = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
				// process the slot whose data just came back
				if (v_s1) begin
					if (st_s1 == ST_COUNTING) begin
						if (fire) begin
							st_we     = 1'b1;
							st_wval   = ST_FIRED;
							pend_load = 1'b1;
							if (pend_v_q) begin
								emit             = 1'b1;
								rsp_d.slot_out   = 8'(pend_slot_q);
								rsp_d.fired      = 1'b1;
								rsp_d.action_out = pend_act_q;
								rsp_d.tag_out    = pend_tag_q;
							end
						end else begin
							ctl.wr_secs     = 1'b1;
							wr_data.seconds = dec;
						end
					end else if (st_s1 == ST_CANCELLED) begin
						st_we   = 1'b1;
						st_wval = ST_FREE;
					end
					if (idx_s1 == IW'(SLOT_COUNT - 1)) begin
						state_d = S_END;
					end
				end
			end
			S_END: begin
				emit       = 1'b1;
				rsp_d.last = 1'b1;
				if (pend_v_q) begin
					rsp_d.slot_out   = 8'(pend_slot_q);
					rsp_d.fired      = 1'b1;
					rsp_d.action_out = pend_act_q;
					rsp_d.tag_out    = pend_tag_q;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				status_q[i] <= ST_FREE;
			end
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			v_s1     <= v_d;
			strobe_q <= emit;
			if (pend_clr) begin
				pend_v_q <= 1'b0;
			end else if (pend_load) begin
				pend_v_q <= 1'b1;
			end
			if (st_we) begin
				status_q[st_widx] <= st_wval;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			cmd_q <= cmd;
		end
		if (v_d) begin
			idx_s1 <= scan_idx;
		end
		if (pend_load) begin
			pend_slot_q <= idx_s1;
			pend_act_q  <= rd_data.action;
			pend_tag_q  <= rd_data.tag;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	// every accepted command either answers next cycle or keeps the block busy
	`CJST_ASSERT(a_accept_progress, clk, arst_n, start && !busy |=> strobe || busy)
	// the end of a tick scan always closes with a final beat
	`CJST_ASSERT(a_end_beat, clk, arst_n, state_q == S_END |=> strobe && rsp.last && !busy)
	// busy only falls together with the final beat of a command
	`CJST_ASSERT(a_busy_fall, clk, arst_n, $fell(busy) |-> strobe && rsp.last)
	// nothing is reported or in progress while reset is held
	`CJST_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !strobe && !busy)

endmodule
